@@ hw/rtl/uniform_block_tree_builder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Tree builder assertion macros
// Shorthand for clocked assertions sampled on clk_i with rst_ni as reset.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_BLOCK_TREE_BUILDER_UNIT_DEFINES_SVH
`define UNIFORM_BLOCK_TREE_BUILDER_UNIT_DEFINES_SVH

// consequent holds in the same cycle
`define UBTB_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tree builder check failed");

// consequent holds in the next cycle
`define UBTB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tree builder check failed");

`endif

@@ hw/rtl/ubtb_pkg.sv @@
// ----------------------------------------------------------------------------
// Tree builder package
// Request types, row entry type and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ubtb_pkg;

  localparam int ValueW  = 24;
  localparam int OffsetW = 32;
  localparam int LevelW  = 3;

  localparam logic [OffsetW-1:0] LeafMark = '1;

  localparam logic OpInsert = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ValueW-1:0] leaf_value;
    logic [LevelW-1:0] start_level;
  } in_req_t;

  typedef struct packed {
    logic [ValueW-1:0]  node_value;
    logic [OffsetW-1:0] child_offset;
    logic [OffsetW-1:0] out_position;
    logic               last;
  } out_req_t;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [OffsetW-1:0] offset;
  } entry_t;

  typedef enum logic [1:0] {
    SrcLeaf   = 2'd0,
    SrcFirst  = 2'd1,
    SrcParent = 2'd2
  } src_e;

  typedef struct packed {
    logic capture;
    logic push;
    src_e push_src;
    logic clr_idx;
    logic inc_idx;
    logic rd;
    logic rd_top;
    logic level_up;
    logic save_start;
    logic load_node;
    logic load_fin;
    logic release_out;
    logic rel_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_finish;
    logic in_skip;
    logic row_full;
    logic idx_last;
    logic same;
    logic out_free;
  } dp_status_t;

endpackage

@@ hw/rtl/uniform_block_tree_builder_unit.sv @@
// ----------------------------------------------------------------------------
// Uniform block tree builder
// Bottom-up builder of a compacted voxel tree from a stream of leaf inserts.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry an insert (leaf_value onto row
// start_level) or a finish request. Output channel: out_valid_o / out_stall_i
// carry emitted nodes; last marks the final node caused by one request.
// One request is worked at a time; in_stall_o is high while it is in flight.
// Each full row is scanned entry by entry; a row that collapses into one
// leaf costs nothing beyond the scan, a row that is emitted is read again
// node by node, since nodes leave through one registered read port of the
// row memory. Finish: the root appears at position 0 with last set.
// An insert to a level at or above LEVELS is taken while idle, no output.
// A stalled output holds its node; emission waits for the register to free,
// while the last node of each request is shown as soon as it is known.
// Reset clears all row fill counts and sets the next output position to 1;
// no clearing pass over the row memory is needed.
// ----------------------------------------------------------------------------
module uniform_block_tree_builder_unit import ubtb_pkg::*; #(
  parameter int TREE_SIZE = 8,
  parameter int LEVELS    = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ubtb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ubtb_dp #(
    .TREE_SIZE (TREE_SIZE),
    .LEVELS    (LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

@@ hw/rtl/ubtb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tree builder controller
// Sequences push, row scan, collapse, emission and finish for one request.
// ----------------------------------------------------------------------------
module ubtb_ctrl import ubtb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_PUSH     = 12'b0000_0000_0010,
    S_CHECK    = 12'b0000_0000_0100,
    S_SCAN     = 12'b0000_0000_1000,
    S_SCAN_END = 12'b0000_0001_0000,
    S_DECIDE   = 12'b0000_0010_0000,
    S_UP_SAME  = 12'b0000_0100_0000,
    S_EMIT_RD  = 12'b0000_1000_0000,
    S_EMIT_LD  = 12'b0001_0000_0000,
    S_UP_PAR   = 12'b0010_0000_0000,
    S_FIN_RD   = 12'b0100_0000_0000,
    S_FIN_LD   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (status_i.in_finish) begin
            state_d = S_FIN_RD;
          end else if (!status_i.in_skip) begin
            state_d = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_src = SrcLeaf;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.row_full) begin
          cmd_o.clr_idx = 1'b1;
          state_d       = S_SCAN;
        end else begin
          cmd_o.release_out = 1'b1;
          cmd_o.rel_last    = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.rd      = 1'b1;
        cmd_o.inc_idx = 1'b1;
        if (status_i.idx_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (status_i.same) begin
          cmd_o.level_up = 1'b1;
          state_d        = S_UP_SAME;
        end else begin
          cmd_o.release_out = 1'b1;
          cmd_o.save_start  = 1'b1;
          cmd_o.clr_idx     = 1'b1;
          state_d           = S_EMIT_RD;
        end
      end
      S_UP_SAME: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_src = SrcFirst;
        state_d        = S_CHECK;
      end
      S_EMIT_RD: begin
        if (status_i.out_free) begin
          cmd_o.rd = 1'b1;
          state_d  = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd_o.load_node = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.level_up = 1'b1;
          state_d        = S_UP_PAR;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = S_EMIT_RD;
        end
      end
      S_UP_PAR: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_src = SrcParent;
        state_d        = S_CHECK;
      end
      S_FIN_RD: begin
        if (status_i.out_free) begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_top = 1'b1;
          state_d      = S_FIN_LD;
        end
      end
      S_FIN_LD: begin
        cmd_o.load_fin = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/ubtb_dp.sv @@
// ----------------------------------------------------------------------------
// Tree builder datapath
// Row memory, fill counters, row scan compare, position counter, output reg.
// ----------------------------------------------------------------------------
module ubtb_dp import ubtb_pkg::*; #(
  parameter int TREE_SIZE = 8,
  parameter int LEVELS    = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_req_t    in_req_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_req_t   out_req_o,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o
);

  localparam int IW    = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;
  localparam int FW    = $clog2(TREE_SIZE + 1);
  localparam int LW    = $clog2(LEVELS + 1);
  localparam int AW    = LW + IW;
  localparam int Depth = (LEVELS + 1) * (2 ** IW);

  entry_t mem [Depth];
  entry_t rd_q;
  logic   rd_vld_q;
  logic [IW-1:0] rd_idx_q;

  logic [FW-1:0] fill_q [LEVELS+1];
  logic [FW-1:0] fill_cur;
  logic [LW-1:0] lvl_q;
  logic [IW-1:0] idx_q;
  logic [ValueW-1:0]  val_q;
  logic [ValueW-1:0]  first_q;
  logic               same_q;
  logic [OffsetW-1:0] start_q;
  logic [OffsetW-1:0] next_free_q;

  out_req_t out_q;
  logic     out_valid_q;
  logic     pend_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  logic          top_used;

  assign fill_cur = fill_q[lvl_q];
  assign top_used = (fill_q[LEVELS] != '0);

  assign mem_we    = cmd_i.push && (fill_cur < FW'(TREE_SIZE));
  assign mem_waddr = {lvl_q, fill_cur[IW-1:0]};
  assign mem_raddr = cmd_i.rd_top ? {LW'(LEVELS), IW'(0)} : {lvl_q, idx_q};

  always_comb begin
    unique case (cmd_i.push_src)
      SrcLeaf:   mem_wdata = '{value: val_q, offset: LeafMark};
      SrcFirst:  mem_wdata = '{value: first_q, offset: LeafMark};
      SrcParent: mem_wdata = '{value: '0, offset: start_q};
      default:   mem_wdata = '{value: '0, offset: start_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign status_o.in_finish = (in_req_i.operation == OpFinish);
  assign status_o.in_skip   = (32'(in_req_i.start_level) >= LEVELS);
  assign status_o.row_full  = (32'(lvl_q) < LEVELS) && (fill_cur == FW'(TREE_SIZE));
  assign status_o.idx_last  = (idx_q == IW'(TREE_SIZE - 1));
  assign status_o.same      = same_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // fill counters, level and index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LEVELS; i++) begin
        fill_q[i] <= '0;
      end
      lvl_q       <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      next_free_q <= 32'd1;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.capture) begin
        lvl_q <= LW'(32'(in_req_i.start_level));
      end else if (cmd_i.level_up) begin
        lvl_q <= lvl_q + LW'(1);
      end
      if (mem_we) begin
        fill_q[lvl_q] <= fill_cur + FW'(1);
      end else if (cmd_i.level_up) begin
        fill_q[lvl_q] <= '0;
      end
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.load_node) begin
        next_free_q <= next_free_q + 32'd1;
      end
    end
  end

  // payload and row compare
  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (cmd_i.capture) begin
      val_q <= in_req_i.leaf_value;
    end
    if (cmd_i.save_start) begin
      start_q <= next_free_q;
    end
    if (rd_vld_q) begin
      if (rd_idx_q == '0) begin
        first_q <= rd_q.value;
        same_q  <= (rd_q.offset == LeafMark);
      end else begin
        same_q <= same_q && (rd_q.value == first_q) && (rd_q.offset == LeafMark);
      end
    end
  end

  // output register, last node of a row held back until last is known
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_node) begin
        if (status_o.idx_last) begin
          pend_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (cmd_i.load_fin) begin
        out_valid_q <= 1'b1;
      end else if (cmd_i.release_out && pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_node) begin
      out_q <= '{node_value: rd_q.value, child_offset: rd_q.offset,
                 out_position: next_free_q, last: 1'b0};
    end else if (cmd_i.load_fin) begin
      out_q <= '{node_value: top_used ? rd_q.value : '0,
                 child_offset: top_used ? rd_q.offset : '0,
                 out_position: '0, last: 1'b1};
    end else if (cmd_i.release_out && pend_q) begin
      out_q.last <= cmd_i.rel_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

@@ hw/rtl/ubtb_checker.sv @@
// ----------------------------------------------------------------------------
// Tree builder port checker
// Checks handshake and node properties seen on the top level ports.
// ----------------------------------------------------------------------------
`include "uniform_block_tree_builder_unit_defines.svh"

module ubtb_checker import ubtb_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_req_t out_req_o
);

  `UBTB_ASSERT_NEXT(a_out_valid_held, out_valid_o && out_stall_i, out_valid_o)
  `UBTB_ASSERT_NEXT(a_out_req_held, out_valid_o && out_stall_i, $stable(out_req_o))
  `UBTB_ASSERT_NEXT(a_finish_busy,
      in_valid_i && !in_stall_o && (in_req_i.operation == OpFinish), in_stall_o)
  `UBTB_ASSERT_SAME(a_interior_empty,
      out_valid_o && (out_req_o.child_offset != LeafMark), out_req_o.node_value == '0)

endmodule

bind uniform_block_tree_builder_unit ubtb_checker u_checker (.*);
